// ===== rtl/cgsp_pkg.sv =====
`timescale 1ns / 1ps
package cgsp_pkg;

   localparam int EXP_DEPTH_DEF = 256;

   // register indexes
   localparam logic [2:0] REG_START_1   = 3'd0;
   localparam logic [2:0] REG_START_2   = 3'd1;
   localparam logic [2:0] REG_DRIFT_1   = 3'd2;
   localparam logic [2:0] REG_DRIFT_2   = 3'd3;
   localparam logic [2:0] REG_SHOCK_1   = 3'd4;
   localparam logic [2:0] REG_SHOCK_2C  = 3'd5;
   localparam logic [2:0] REG_SHOCK_2O  = 3'd6;
   localparam logic [2:0] REG_STRIKE    = 3'd7;

   localparam logic [31:0] START_RST = 32'd6553600;

   localparam logic signed [34:0] CLAMP_LOG = 35'sd8589934592;
   localparam logic signed [32:0] LOG2E_Q28 = 33'sd387270501;
   localparam logic [63:0]        LN2_Q31   = 64'd1488522236;
   localparam logic [55:0]        SUM_MAX   = {56{1'b1}};
   localparam logic [23:0]        COUNT_MAX = {24{1'b1}};

   typedef struct packed {
      logic signed [15:0] normal_1;
      logic signed [15:0] normal_2;
      logic               last_step;
      logic               first_path;
   } req_type;

   typedef struct packed {
      logic [31:0] end_price_1;
      logic [31:0] end_price_2;
      logic [31:0] payoff;
      logic [55:0] payoff_sum;
      logic [23:0] path_count;
   } rsp_type;

   // division by the series index, one constant divisor per arm
   function automatic logic [63:0] div_small(input logic [63:0] x, input int n);
      logic [63:0] q;
      case (n)
         1:  q = x;
         2:  q = x / 2;
         3:  q = x / 3;
         4:  q = x / 4;
         5:  q = x / 5;
         6:  q = x / 6;
         7:  q = x / 7;
         8:  q = x / 8;
         9:  q = x / 9;
         10: q = x / 10;
         11: q = x / 11;
         12: q = x / 12;
         13: q = x / 13;
         14: q = x / 14;
         15: q = x / 15;
         16: q = x / 16;
         17: q = x / 17;
         18: q = x / 18;
         19: q = x / 19;
         20: q = x / 20;
         21: q = x / 21;
         22: q = x / 22;
         23: q = x / 23;
         24: q = x / 24;
         default: q = '0;
      endcase
      return q;
   endfunction

   // exp(z) for Q.31 z by truncated Taylor series, result Q1.30
   function automatic logic [31:0] exp_entry(input logic [63:0] z);
      logic [63:0] term;
      logic [63:0] sum;
      term = 64'd1 << 31;
      sum  = term;
      for (int n = 1; n <= 24; n++) begin
         if (term != 64'd0) begin
            term = div_small((term * z) >> 31, n);
            sum  = sum + term;
         end
      end
      return 32'((sum + 64'd1) >> 1);
   endfunction

endpackage

// ===== rtl/cgsp_req_if.sv =====
`timescale 1ns / 1ps
interface cgsp_req_if;
   logic             valid;
   logic             ready;
   cgsp_pkg::req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/cgsp_rsp_if.sv =====
`timescale 1ns / 1ps
interface cgsp_rsp_if;
   logic             valid;
   logic             ready;
   cgsp_pkg::rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/cgsp_mul.sv =====
`timescale 1ns / 1ps
// shared signed multiplier, product registered
module cgsp_mul (
   input  logic               clock,
   input  logic signed [34:0] a,
   input  logic signed [32:0] b,
   output logic signed [63:0] prod_ff
);
   logic signed [67:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in[63:0];
   end
endmodule

// ===== rtl/cgsp_exp_rom.sv =====
`timescale 1ns / 1ps
// 2^(k/depth) table in unsigned Q2.30, entries idx and idx+1, registered
module cgsp_exp_rom #(
   parameter int EXP_TABLE_DEPTH = cgsp_pkg::EXP_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] idx,
   output logic [31:0]                        lo_ff,
   output logic [31:0]                        hi_ff
);
   import cgsp_pkg::*;

   localparam int IdxW = $clog2(EXP_TABLE_DEPTH);

   logic [31:0] tab [EXP_TABLE_DEPTH+1];

   for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_tab
      localparam logic [63:0] Z =
         (64'(k) * LN2_Q31 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
      if (k == 0) begin : g_first
         assign tab[k] = 32'd1 << 30;
      end else if (k == EXP_TABLE_DEPTH) begin : g_last
         assign tab[k] = 32'd1 << 31;
      end else begin : g_mid
         localparam logic [31:0] ENTRY = exp_entry(Z);
         assign tab[k] = ENTRY;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= tab[idx];
      hi_ff <= tab[(IdxW+1)'(idx) + 1'b1];
   end
endmodule

// ===== rtl/correlated_gbm_spread_payoff.sv =====
`timescale 1ns / 1ps
// Two-asset correlated GBM path stepper with call-spread payoff.
// req_if: one beat per time step: two Q3.12 normal samples, last_step and
//   first_path. first_path clears the payoff sum and path count on accept.
// rsp_if: one beat per completed path (only for beats with last_step):
//   both end prices, payoff, running payoff sum and path count.
// csr_*: write-only registers; user writes only while idle, not enforced.
// Sequence: a step is accepted, then makes three multiplier passes
//   through the one shared multiplier, then the second log sum update.
//   A last step adds the two exponentials (five multiplier/shift
//   passes each) and the payoff state that loads the result register.
//   A new step is accepted only while the block is idle.
// Result register: the next step is taken while a result waits; a second
//   result stalls in the payoff state until rsp_if.ready frees the register.
// Reset: synchronous, active high; registers return to their reset values,
//   log sums, payoff sum and count go to zero, no result is held.
// EXP_TABLE_DEPTH must be a power of two (64..4096).
module correlated_gbm_spread_payoff #(
   parameter int EXP_TABLE_DEPTH = cgsp_pkg::EXP_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cgsp_req_if.sink    req_if,
   cgsp_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import cgsp_pkg::*;

   localparam int IdxW = $clog2(EXP_TABLE_DEPTH);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_P1   = 4'd1;   // shock_1 * n1
   localparam logic [3:0] ST_P2   = 4'd2;   // common * n1, update log 1
   localparam logic [3:0] ST_P3   = 4'd3;   // own * n2
   localparam logic [3:0] ST_P4   = 4'd4;   // update log 2
   localparam logic [3:0] ST_E1   = 4'd5;   // clamp, times log2(e)
   localparam logic [3:0] ST_E2   = 4'd6;   // split int/frac, table read
   localparam logic [3:0] ST_E3   = 4'd7;   // interpolation product
   localparam logic [3:0] ST_E4   = 4'd8;   // start * v
   localparam logic [3:0] ST_E5   = 4'd9;   // scale by 2^n, saturate
   localparam logic [3:0] ST_PAY  = 4'd10;  // payoff, sums, result load

   // registers
   logic [31:0]        start1_ff, start2_ff, strike_ff;
   logic signed [31:0] drift1_ff, drift2_ff, sc2_ff;
   logic [30:0]        shock1_ff, so2_ff;

   logic [3:0]         state_ff, state_in;
   logic               asset_ff;
   logic signed [39:0] log1_ff, log2_ff;
   logic [55:0]        sum_ff;
   logic [23:0]        count_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // item payload and intermediates
   logic signed [15:0] n1_ff, n2_ff;
   logic               last_ff;
   logic signed [47:0] tmp_ff;
   logic signed [8:0]  exp_n_ff;
   logic [IdxW-1:0]    idx_ff;
   logic [27:0]        w_ff;
   logic [31:0]        e1_ff, e2_ff;

   logic               req_fire;
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // shared multiplier
   logic signed [34:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [63:0] prod_ff;

   cgsp_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   // exp table
   logic [IdxW-1:0] rom_idx;
   logic [31:0]     lo_ff, hi_ff;

   cgsp_exp_rom #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_rom (
      .clock (clock),
      .idx   (rom_idx),
      .lo_ff (lo_ff),
      .hi_ff (hi_ff)
   );

   // selected asset
   logic signed [39:0] log_sel;
   logic [31:0]        start_sel;
   assign log_sel   = asset_ff ? log2_ff : log1_ff;
   assign start_sel = asset_ff ? start2_ff : start1_ff;

   // clamp to +/-32 in Q.28
   logic signed [34:0] x_clamp;
   always_comb begin
      if (log_sel > 40'(CLAMP_LOG))       x_clamp = CLAMP_LOG;
      else if (log_sel < -40'(CLAMP_LOG)) x_clamp = -CLAMP_LOG;
      else                                x_clamp = 35'(log_sel);
   end

   // log2 domain value, rounded half up to Q.28
   // table index follows y in E2, then holds so lo/hi stay put through E4
   logic signed [36:0] y_val;
   assign y_val   = 37'((prod_ff + 64'sd134217728) >>> 28);
   assign rom_idx = (state_ff == ST_E2) ? y_val[27 -: IdxW] : idx_ff;

   // interpolation
   logic [31:0] diff;
   logic [31:0] v_val;
   assign diff  = (hi_ff >= lo_ff) ? (hi_ff - lo_ff) : 32'd0;
   assign v_val = lo_ff + 32'(prod_ff >>> 28);

   // scale by 2^n: shift right by s = 30 - n with rounding, or left
   logic signed [9:0] s_val;
   logic [63:0]       prod_u;
   logic [5:0]        lsh;
   logic [6:0]        rsh;
   logic [63:0]       r_val;
   logic [31:0]       price;
   assign s_val  = 10'sd30 - 10'(exp_n_ff);
   assign prod_u = prod_ff;
   assign lsh    = 6'(-s_val);
   assign rsh    = 7'(s_val);

   always_comb begin
      r_val = '0;
      if (prod_u == 64'd0) begin
         price = '0;
      end else if (s_val <= 10'sd0) begin
         if (lsh >= 6'd32)                          price = '1;
         else if ((prod_u >> (6'd32 - lsh)) != '0)  price = '1;
         else                                       price = 32'(prod_u << lsh);
      end else if (s_val >= 10'sd64) begin
         price = '0;
      end else begin
         r_val = (prod_u + (64'd1 << (rsh - 7'd1))) >> rsh;
         price = (r_val[63:32] != '0) ? '1 : r_val[31:0];
      end
   end

   // step increments
   logic signed [48:0] rnd1;
   logic signed [49:0] rnd2;
   logic signed [40:0] new_log1, new_log2;
   logic signed [39:0] sat_log1, sat_log2;
   assign rnd1 = 49'(prod_ff) + 49'sd2048;
   assign rnd2 = 50'(tmp_ff) + 50'(prod_ff) + 50'sd2048;
   assign new_log1 = 41'(log1_ff) + 41'(drift1_ff) + 41'(rnd1 >>> 12);
   assign new_log2 = 41'(log2_ff) + 41'(drift2_ff) + 41'(rnd2 >>> 12);
   assign sat_log1 = (new_log1[40] != new_log1[39]) ?
                     {new_log1[40], {39{~new_log1[40]}}} : new_log1[39:0];
   assign sat_log2 = (new_log2[40] != new_log2[39]) ?
                     {new_log2[40], {39{~new_log2[40]}}} : new_log2[39:0];

   // payoff
   logic signed [33:0] spread;
   logic [31:0]        pay;
   logic [56:0]        sum_add;
   logic [55:0]        sum_next;
   logic [23:0]        count_next;
   logic               pay_load;
   assign spread     = 34'(e2_ff) - 34'(e1_ff) - 34'(strike_ff);
   assign pay        = (spread > 34'sd0) ? spread[31:0] : 32'd0;
   assign sum_add    = 57'(sum_ff) + 57'(pay);
   assign sum_next   = sum_add[56] ? SUM_MAX : sum_add[55:0];
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 24'd1;
   assign pay_load   = (state_ff == ST_PAY) && (!rsp_valid_ff || rsp_if.ready);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_P1: begin
            mul_a = 35'($signed({1'b0, shock1_ff}));
            mul_b = 33'(n1_ff);
         end
         ST_P2: begin
            mul_a = 35'(sc2_ff);
            mul_b = 33'(n1_ff);
         end
         ST_P3: begin
            mul_a = 35'($signed({1'b0, so2_ff}));
            mul_b = 33'(n2_ff);
         end
         ST_E1: begin
            mul_a = x_clamp;
            mul_b = LOG2E_Q28;
         end
         ST_E3: begin
            mul_a = 35'($signed({1'b0, diff}));
            mul_b = 33'($signed({1'b0, w_ff}));
         end
         ST_E4: begin
            mul_a = 35'($signed({1'b0, start_sel}));
            mul_b = 33'($signed({1'b0, v_val}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_P1;
         ST_P1:   state_in = ST_P2;
         ST_P2:   state_in = ST_P3;
         ST_P3:   state_in = ST_P4;
         ST_P4:   state_in = last_ff ? ST_E1 : ST_IDLE;
         ST_E1:   state_in = ST_E2;
         ST_E2:   state_in = ST_E3;
         ST_E3:   state_in = ST_E4;
         ST_E4:   state_in = ST_E5;
         ST_E5:   state_in = asset_ff ? ST_PAY : ST_E1;
         ST_PAY:  if (pay_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         asset_ff     <= 1'b0;
         log1_ff      <= '0;
         log2_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         start1_ff    <= START_RST;
         start2_ff    <= START_RST;
         drift1_ff    <= '0;
         drift2_ff    <= '0;
         shock1_ff    <= '0;
         sc2_ff       <= '0;
         so2_ff       <= '0;
         strike_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               REG_START_1:  start1_ff <= csr_wdata;
               REG_START_2:  start2_ff <= csr_wdata;
               REG_DRIFT_1:  drift1_ff <= csr_wdata;
               REG_DRIFT_2:  drift2_ff <= csr_wdata;
               REG_SHOCK_1:  shock1_ff <= csr_wdata[30:0];
               REG_SHOCK_2C: sc2_ff    <= csr_wdata;
               REG_SHOCK_2O: so2_ff    <= csr_wdata[30:0];
               REG_STRIKE:   strike_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_fire && req_if.data.first_path) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end
         if (state_ff == ST_P2) log1_ff <= sat_log1;
         if (state_ff == ST_P4) log2_ff <= sat_log2;
         if (state_ff == ST_E5) asset_ff <= ~asset_ff;
         if (pay_load) begin
            rsp_valid_ff <= 1'b1;
            sum_ff       <= sum_next;
            count_ff     <= count_next;
            log1_ff      <= '0;
            log2_ff      <= '0;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         n1_ff   <= req_if.data.normal_1;
         n2_ff   <= req_if.data.normal_2;
         last_ff <= req_if.data.last_step;
      end
      if (state_ff == ST_P3) tmp_ff <= prod_ff[47:0];
      if (state_ff == ST_E2) begin
         exp_n_ff <= y_val[36:28];
         idx_ff   <= rom_idx;
         w_ff     <= 28'(y_val[27:0] << IdxW);
      end
      if (state_ff == ST_E5) begin
         if (asset_ff) e2_ff <= price;
         else          e1_ff <= price;
      end
      if (pay_load) begin
         rsp_data_ff.end_price_1 <= e1_ff;
         rsp_data_ff.end_price_2 <= e2_ff;
         rsp_data_ff.payoff      <= pay;
         rsp_data_ff.payoff_sum  <= sum_next;
         rsp_data_ff.path_count  <= count_next;
      end
   end

`ifndef ASSERT_OFF
   a_rsp_from_pay: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PAY))
      else $error("result appeared outside payoff state");

   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (count_ff < $past(count_ff)) |-> $past(req_fire && req_if.data.first_path))
      else $error("path count fell without a clear");

   a_log_cleared: assert property (@(posedge clock) disable iff (reset)
      $past(pay_load) |-> (log1_ff == '0 && log2_ff == '0))
      else $error("log sums not cleared at path end");

   a_idx_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_E4) |-> (idx_ff == $past(idx_ff)))
      else $error("table index moved during interpolation");
`endif
endmodule
